FILE: hw/rtl/calo_cone_isolation_sum_assert.svh
// assertion macros shared by the cone isolation rtl
`ifndef CALO_CONE_ISOLATION_SUM_ASSERT_SVH
`define CALO_CONE_ISOLATION_SUM_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CCISO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCISO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cciso_pkg.sv
// shared types, widths and codes of the cone isolation block
package cciso_pkg;

  localparam int ETA_W   = 11;
  localparam int PHI_W   = 10;
  localparam int E_W     = 16;
  localparam int SUM_W   = 24;
  localparam int DR_W    = 23;
  localparam int DETA_W  = 11;
  localparam int MODE_W  = 2;
  localparam int DEP_W   = ETA_W + PHI_W + E_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [DR_W-1:0]   MAX_DR_SQ_RST = 23'd4225;
  localparam logic [DR_W-1:0]   MIN_DR_SQ_RST = 23'd0;
  localparam logic [DETA_W-1:0] MIN_DETA_RST  = 11'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_DR_SQ = 2'd0,
    CFG_MIN_DR_SQ = 2'd1,
    CFG_MIN_DETA  = 2'd2
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic wr_en;
    logic latch_cand;
    logic clear_acc;
    logic rd_en;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_valid;
  } status_t;

endpackage

FILE: hw/rtl/cciso_ctrl.sv
// controller: deposit count, table walk sequencing and result hand-off
`include "calo_cone_isolation_sum_assert.svh"

module cciso_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cciso_pkg::mode_t           mode,
  input  logic                       out_ready,
  input  cciso_pkg::status_t         status,
  output cciso_pkg::cmd_t            cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr
);
  import cciso_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    rd_idx;
  logic             accept;
  logic             full;
  logic             last_rd;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign last_rd  = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign wr_addr  = count[AW-1:0];
  assign rd_addr  = rd_idx;

  always_comb begin
    cmd            = '0;
    cmd.wr_en      = accept && (mode == MODE_LOAD) && !full;
    cmd.latch_cand = accept && (mode == MODE_QUERY);
    cmd.clear_acc  = accept && (mode == MODE_QUERY);
    cmd.rd_en      = (state == S_WALK);
    cmd.load_out   = (state == S_DONE) && (!status.out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_CLEAR: count <= '0;
              MODE_LOAD: begin
                if (!full) count <= count + CNT_W'(1);
              end
              MODE_QUERY: begin
                rd_idx <= '0;
                state  <= (count == '0) ? S_DRAIN : S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          rd_idx <= rd_idx + AW'(1);
          if (last_rd) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!status.pipe_busy) state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CCISO_ASSERT_NOW(a_wr_below_depth, cmd.wr_en, count < CNT_W'(TABLE_DEPTH), "load past table end")
  `CCISO_ASSERT_NOW(a_out_after_drain, cmd.load_out, !status.pipe_busy, "result taken before pipeline drained")
  `CCISO_ASSERT_NEXT(a_walk_keeps_count, state == S_WALK, $stable(count), "count moved during walk")

endmodule

FILE: hw/rtl/cciso_datapath.sv
// datapath: deposit memory, distance pipeline, accumulators, config and output registers
`include "calo_cone_isolation_sum_assert.svh"

module cciso_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cciso_pkg::cmd_t                       cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  input  logic [cciso_pkg::ETA_W-1:0]           in_eta,
  input  logic [cciso_pkg::PHI_W-1:0]           in_phi,
  input  logic [cciso_pkg::E_W-1:0]             in_energy,
  input  logic                                  cfg_we,
  input  logic [cciso_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cciso_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  out_ready,
  output cciso_pkg::status_t                    status,
  output logic [cciso_pkg::SUM_W-1:0]           out_cone,
  output logic [cciso_pkg::SUM_W-1:0]           out_ann
);
  import cciso_pkg::*;

  // config registers
  logic [DR_W-1:0]   max_dr_sq;
  logic [DR_W-1:0]   min_dr_sq;
  logic [DETA_W-1:0] min_deta;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dr_sq <= MAX_DR_SQ_RST;
      min_dr_sq <= MIN_DR_SQ_RST;
      min_deta  <= MIN_DETA_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MAX_DR_SQ: max_dr_sq <= cfg_wdata[DR_W-1:0];
        CFG_MIN_DR_SQ: min_dr_sq <= cfg_wdata[DR_W-1:0];
        CFG_MIN_DETA:  min_deta  <= cfg_wdata[DETA_W-1:0];
        default: ;
      endcase
    end
  end

  // deposit table, word = {energy, phi, eta}
  logic [DEP_W-1:0] mem [TABLE_DEPTH];
  logic [DEP_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= {in_energy, in_phi, in_eta};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  // candidate position
  logic [ETA_W-1:0] cand_eta;
  logic [PHI_W-1:0] cand_phi;

  always_ff @(posedge clk) begin
    if (cmd.latch_cand) begin
      cand_eta <= in_eta;
      cand_phi <= in_phi;
    end
  end

  // stage valids
  logic v1, v2, v3, v4;

  // stage 2: absolute differences
  logic signed [ETA_W:0] de;
  logic [ETA_W-1:0]      ade_c;
  logic [PHI_W-1:0]      dp;
  logic [PHI_W-1:0]      adp_c;
  logic [ETA_W-1:0]      d_eta;
  logic [PHI_W-1:0]      d_phi;
  logic [E_W-1:0]        d_w;

  assign d_eta = rd_data[ETA_W-1:0];
  assign d_phi = rd_data[ETA_W +: PHI_W];
  assign d_w   = rd_data[ETA_W+PHI_W +: E_W];
  assign de    = $signed({cand_eta[ETA_W-1], cand_eta}) - $signed({d_eta[ETA_W-1], d_eta});
  assign ade_c = de[ETA_W] ? ETA_W'(-de) : de[ETA_W-1:0];
  assign dp    = cand_phi - d_phi;
  // wrap to the short way round the circle
  assign adp_c = dp[PHI_W-1] ? PHI_W'(-dp) : dp;

  logic [ETA_W-1:0] ade2;
  logic [PHI_W-1:0] adp2;
  logic [E_W-1:0]   w2;

  always_ff @(posedge clk) begin
    ade2 <= ade_c;
    adp2 <= adp_c;
    w2   <= d_w;
  end

  // stage 3: squares
  logic [2*ETA_W-1:0] sq_e3;
  logic [2*PHI_W-1:0] sq_p3;
  logic [ETA_W-1:0]   ade3;
  logic [E_W-1:0]     w3;

  always_ff @(posedge clk) begin
    sq_e3 <= (2*ETA_W)'(ade2) * (2*ETA_W)'(ade2);
    sq_p3 <= (2*PHI_W)'(adp2) * (2*PHI_W)'(adp2);
    ade3  <= ade2;
    w3    <= w2;
  end

  // stage 4: distance and window tests
  logic [DR_W-1:0] dr;
  logic            cone4;
  logic            ann4;
  logic [E_W-1:0]  w4;

  assign dr = DR_W'(sq_e3) + DR_W'(sq_p3);

  always_ff @(posedge clk) begin
    cone4 <= (dr <= max_dr_sq);
    ann4  <= (dr <= max_dr_sq) && (dr >= min_dr_sq) && (ade3 >= min_deta);
    w4    <= w3;
  end

  // saturating accumulators
  logic [SUM_W-1:0] cone_acc;
  logic [SUM_W-1:0] ann_acc;
  logic [SUM_W:0]   cone_s;
  logic [SUM_W:0]   ann_s;

  assign cone_s = {1'b0, cone_acc} + (SUM_W+1)'(w4);
  assign ann_s  = {1'b0, ann_acc} + (SUM_W+1)'(w4);

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      cone_acc <= '0;
      ann_acc  <= '0;
    end else if (v4) begin
      if (cone4) cone_acc <= cone_s[SUM_W] ? '1 : cone_s[SUM_W-1:0];
      if (ann4)  ann_acc  <= ann_s[SUM_W] ? '1 : ann_s[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // output register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cone <= cone_acc;
      out_ann  <= ann_acc;
    end
  end

  assign status.pipe_busy = v1 || v2 || v3 || v4;
  assign status.out_valid = out_valid;

  `CCISO_ASSERT_NOW(a_ann_inside_cone, v4 && ann4, cone4, "annulus hit outside cone")
  `CCISO_ASSERT_NOW(a_ann_le_cone, out_valid, out_ann <= out_cone, "annulus sum above cone sum")
  `CCISO_ASSERT_NOW(a_clear_when_empty, cmd.clear_acc, !(v1 || v2 || v3 || v4), "accumulators cleared mid walk")

endmodule

FILE: hw/rtl/calo_cone_isolation_sum.sv
// top level of the calorimeter cone isolation sum block
// Calorimeter cone isolation sum. Loads calorimeter deposits (eta, phi, weight) into a
// table of TABLE_DEPTH entries and, for each query beat, walks the stored deposits and
// returns a cone sum (all deposits within the outer radius, squared distance at most
// max_dr_sq) and an annulus sum (additionally at least min_dr_sq and with absolute eta
// difference at least min_deta). Phi differences wrap around the 1024-code circle; both
// sums saturate at 2^24-1. Clear and load beats leave the block idle. For a query the
// walk issues one table read per stored deposit, one per cycle, from the single memory
// read port, then a five-stage read / difference / square / compare / accumulate
// pipeline drains before the result is loaded into the output register. An empty table
// skips the walk and goes straight to the drain state, which ends at once as no read
// is in flight.
// The block takes one beat at a time; the result sits in an output register so the
// next beat is accepted while it waits, and a following query only stalls at its own
// end if the previous result was still not taken. Configuration writes go straight to
// their registers and are expected only while the block is idle.
`include "calo_cone_isolation_sum_assert.svh"

module calo_cone_isolation_sum #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input beats
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [cciso_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // eta[10:0], phi[20:11], energy[36:21]
  input  logic [cciso_pkg::MODE_W-1:0]         s_axis_tuser,  // mode[1:0]
  // result beats
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [cciso_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // cone_sum[23:0], annulus_sum[47:24]
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [cciso_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cciso_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cciso_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  cmd_t             cmd;
  status_t          status;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [SUM_W-1:0] cone_sum;
  logic [SUM_W-1:0] annulus_sum;
  mode_t            mode;

  // input beat unpacking
  assign mode = mode_t'(s_axis_tuser);

  cciso_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .mode     (mode),
    .out_ready(m_axis_tready),
    .status   (status),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  cciso_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .in_eta   (s_axis_tdata[ETA_W-1:0]),
    .in_phi   (s_axis_tdata[ETA_W +: PHI_W]),
    .in_energy(s_axis_tdata[ETA_W+PHI_W +: E_W]),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_ready(m_axis_tready),
    .status   (status),
    .out_cone (cone_sum),
    .out_ann  (annulus_sum)
  );

  // result beat packing
  assign m_axis_tvalid = status.out_valid;
  assign m_axis_tdata  = {annulus_sum, cone_sum};

  // a query never finishes without its result beat being raised next cycle
  `CCISO_ASSERT_NEXT(a_result_raised, cmd.load_out, m_axis_tvalid, "result beat not raised")
  // no input beat is taken while a query is running
  `CCISO_ASSERT_NOW(a_no_accept_busy, status.pipe_busy, !s_axis_tready, "input taken during walk")
  // sums report ann not above cone at the port
  `CCISO_ASSERT_NOW(a_port_ann_le_cone, m_axis_tvalid, annulus_sum <= cone_sum, "annulus above cone at port")

endmodule
